// ----- design/sepf_pkg.sv -----
// Shared types, codes and the CRC byte update for the secure-element packet framer.
package sepf_pkg;

    // Limits on command data length and response length.
    localparam logic [6:0] MAX_DATA    = 7'd64;
    localparam logic [6:0] MAX_READ    = 7'd67;
    localparam logic [6:0] SHORT_REPLY = 7'd4;

    // Framing constants.
    localparam logic [15:0] CRC_POLY = 16'h8005;
    localparam logic [7:0]  WORD_CMD = 8'h03;
    localparam logic [7:0]  OVERHEAD = 8'd7;

    // Input word kinds.
    localparam logic [1:0] MODE_HDR  = 2'd0;
    localparam logic [1:0] MODE_DATA = 2'd1;
    localparam logic [1:0] MODE_RESP = 2'd2;

    // Response verdict codes.
    localparam logic [1:0] VERDICT_OK      = 2'd0;
    localparam logic [1:0] VERDICT_CRC     = 2'd1;
    localparam logic [1:0] VERDICT_DEVICE  = 2'd2;
    localparam logic [1:0] VERDICT_INVALID = 2'd3;

    // Link phase, one-hot.
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_DATA = 3'b010,
        PH_READ = 3'b100
    } t_phase;

    // Input word.
    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  opcode;
        logic [7:0]  param_one;
        logic [15:0] param_two;
        logic [6:0]  data_len;
        logic [7:0]  data_byte;
        logic        first;
        logic [6:0]  read_len;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       verdict_valid;
        logic [1:0] verdict;
        logic [7:0] dev_status;
        logic       last;
    } t_out_word;

    // CRC-16 update by one byte, data bits taken least significant first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in;
        for (int i = 0; i < 8; i++) begin
            if (b[i] != c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- design/secure_element_packet_framer.sv -----
// Packet framer and response checker for a secure-element serial link.
// An accepted word waits in the input holding register; its results go to the single output
// register, one result word a cycle while the receiver does not stall. A header sends the
// command word, count, opcode and parameters, then the CRC trailer if its data is empty; a
// data word its byte (and the trailer after the last). Words with no result skip the output.
// Reset is synchronous, active low, and returns the block to idle, CRC and all counters cleared.
module secure_element_packet_framer
    import sepf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    // Input holding register and sequencing.
    t_in_word    r_in;
    logic        r_in_full;
    logic [2:0]  r_step;
    logic [2:0]  n_step;

    // Output register.
    t_out_word   r_out;
    logic        r_out_valid;

    // Link state.
    t_phase      r_phase, n_phase;
    logic [15:0] r_crc, n_crc;
    logic [6:0]  r_data_left, n_data_left;
    logic [6:0]  r_read_pos, n_read_pos;
    logic [6:0]  r_read_total, n_read_total;
    logic [7:0]  r_reply_count, n_reply_count;
    logic [7:0]  r_status_byte, n_status_byte;
    logic [7:0]  r_crc_low_seen, n_crc_low_seen;
    logic        r_crc_match, n_crc_match;

    // Step results.
    logic        emit;
    logic        fin;
    t_out_word   w;
    logic [15:0] crc_src;
    logic [7:0]  crc_in;
    logic [15:0] crc_step;
    logic [6:0]  len_sat;
    logic [6:0]  rl_sat;
    logic [8:0]  pos_plus2;
    logic [1:0]  verdict;
    logic        out_ready;
    logic        go;
    logic        in_accept;

    // Shared CRC byte unit.
    assign crc_step = crc_byte(crc_src, crc_in);

    // Saturated lengths.
    assign len_sat = (r_in.data_len > MAX_DATA) ? MAX_DATA : r_in.data_len;
    always_comb begin
        if (r_in.read_len < SHORT_REPLY) begin
            rl_sat = SHORT_REPLY;
        end else if (r_in.read_len > MAX_READ) begin
            rl_sat = MAX_READ;
        end else begin
            rl_sat = r_in.read_len;
        end
    end

    // One step of the word in the holding register.
    always_comb begin
        n_phase        = r_phase;
        n_crc          = r_crc;
        n_data_left    = r_data_left;
        n_read_pos     = r_read_pos;
        n_read_total   = r_read_total;
        n_reply_count  = r_reply_count;
        n_status_byte  = r_status_byte;
        n_crc_low_seen = r_crc_low_seen;
        n_crc_match    = r_crc_match;
        emit           = 1'b0;
        fin            = 1'b1;
        w              = '0;
        crc_src        = r_crc;
        crc_in         = 8'h00;
        pos_plus2      = '0;
        verdict        = VERDICT_OK;

        case (r_in.mode)
            MODE_HDR: begin
                emit       = 1'b1;
                w.tx_valid = 1'b1;
                case (r_step)
                    3'd0: begin
                        w.tx_byte = WORD_CMD;
                        n_crc     = '0;
                        fin       = 1'b0;
                    end
                    3'd1: begin
                        w.tx_byte = OVERHEAD + {1'b0, len_sat};
                        fin       = 1'b0;
                    end
                    3'd2: begin
                        w.tx_byte = r_in.opcode;
                        fin       = 1'b0;
                    end
                    3'd3: begin
                        w.tx_byte = r_in.param_one;
                        fin       = 1'b0;
                    end
                    3'd4: begin
                        w.tx_byte = r_in.param_two[7:0];
                        fin       = 1'b0;
                    end
                    3'd5: begin
                        w.tx_byte = r_in.param_two[15:8];
                        if (len_sat == '0) begin
                            fin = 1'b0;
                        end else begin
                            n_data_left = len_sat;
                            n_phase     = PH_DATA;
                        end
                    end
                    3'd6: begin
                        w.tx_byte = r_crc[7:0];
                        fin       = 1'b0;
                    end
                    default: begin
                        w.tx_byte = r_crc[15:8];
                        n_phase   = PH_IDLE;
                    end
                endcase
                // Bytes from count through the second parameter feed the CRC.
                crc_in = w.tx_byte;
                if (r_step >= 3'd1 && r_step <= 3'd5) begin
                    n_crc = crc_step;
                end
            end

            MODE_DATA: begin
                case (r_step)
                    3'd0: begin
                        if (r_phase == PH_DATA && r_data_left != '0) begin
                            emit        = 1'b1;
                            w.tx_valid  = 1'b1;
                            w.tx_byte   = r_in.data_byte;
                            crc_in      = r_in.data_byte;
                            n_crc       = crc_step;
                            n_data_left = r_data_left - 7'd1;
                            fin         = (r_data_left != 7'd1);
                        end
                    end
                    3'd1: begin
                        emit       = 1'b1;
                        w.tx_valid = 1'b1;
                        w.tx_byte  = r_crc[7:0];
                        fin        = 1'b0;
                    end
                    default: begin
                        emit       = 1'b1;
                        w.tx_valid = 1'b1;
                        w.tx_byte  = r_crc[15:8];
                        n_phase    = PH_IDLE;
                    end
                endcase
            end

            MODE_RESP: begin
                crc_in = r_in.data_byte;
                if (r_in.first) begin
                    // First byte restarts a read; it is the count byte.
                    crc_src        = '0;
                    n_read_total   = rl_sat;
                    n_read_pos     = '0;
                    n_reply_count  = r_in.data_byte;
                    n_status_byte  = '0;
                    n_crc_low_seen = '0;
                    n_crc_match    = 1'b0;
                    n_crc          = crc_step;
                    n_phase        = PH_READ;
                end else if (r_phase == PH_READ) begin
                    n_read_pos = r_read_pos + 7'd1;
                    pos_plus2  = {2'b00, n_read_pos} + 9'd2;
                    if (n_read_pos == 7'd1) begin
                        n_status_byte = r_in.data_byte;
                    end
                    if (r_reply_count >= {1'b0, SHORT_REPLY}) begin
                        if (pos_plus2 < {1'b0, r_reply_count}) begin
                            n_crc = crc_step;
                        end else if (pos_plus2 == {1'b0, r_reply_count}) begin
                            n_crc_low_seen = r_in.data_byte;
                        end else if (pos_plus2 == {1'b0, r_reply_count} + 9'd1) begin
                            n_crc_match = (r_crc_low_seen == r_crc[7:0]) &&
                                          (r_in.data_byte == r_crc[15:8]);
                        end
                    end
                end

                // Verdict on the last byte of the read.
                if ((r_in.first || r_phase == PH_READ) &&
                    ({1'b0, n_read_pos} + 8'd1 >= {1'b0, n_read_total})) begin
                    if (n_reply_count < {1'b0, SHORT_REPLY} ||
                        n_reply_count > {1'b0, n_read_total}) begin
                        verdict = VERDICT_CRC;
                    end else if (!n_crc_match) begin
                        verdict = VERDICT_CRC;
                    end else if (n_reply_count == {1'b0, SHORT_REPLY} &&
                                 n_status_byte != '0) begin
                        verdict = VERDICT_DEVICE;
                    end else if (n_reply_count != {1'b0, n_read_total}) begin
                        verdict = VERDICT_INVALID;
                    end else begin
                        verdict = VERDICT_OK;
                    end
                    emit            = 1'b1;
                    w.verdict_valid = 1'b1;
                    w.verdict       = verdict;
                    if (n_reply_count == {1'b0, SHORT_REPLY} && n_crc_match) begin
                        w.dev_status = n_status_byte;
                    end
                    n_phase = PH_IDLE;
                end
            end

            default: begin
                fin = 1'b1;
            end
        endcase

        w.last = fin;
        n_step = fin ? 3'd0 : r_step + 3'd1;
    end

    // Handshake glue.
    assign out_ready  = !r_out_valid || !i_out_stall;
    assign go         = r_in_full && (out_ready || !emit);
    assign o_in_stall = r_in_full && !(go && fin);
    assign in_accept  = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_word;
        end
        if (go && emit) begin
            r_out <= w;
        end
    end

    // Control and link state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_full      <= 1'b0;
            r_step         <= '0;
            r_out_valid    <= 1'b0;
            r_phase        <= PH_IDLE;
            r_crc          <= '0;
            r_data_left    <= '0;
            r_read_pos     <= '0;
            r_read_total   <= '0;
            r_reply_count  <= '0;
            r_status_byte  <= '0;
            r_crc_low_seen <= '0;
            r_crc_match    <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_full <= 1'b1;
            end else if (go && fin) begin
                r_in_full <= 1'b0;
            end

            if (go && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (go) begin
                r_step         <= n_step;
                r_phase        <= n_phase;
                r_crc          <= n_crc;
                r_data_left    <= n_data_left;
                r_read_pos     <= n_read_pos;
                r_read_total   <= n_read_total;
                r_reply_count  <= n_reply_count;
                r_status_byte  <= n_status_byte;
                r_crc_low_seen <= n_crc_low_seen;
                r_crc_match    <= n_crc_match;
            end
        end
    end

    // The step counter only runs while a word is held.
    a_step_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_full |-> r_step == 3'd0)
        else $error("step counter nonzero with empty holding register");

    // A framed byte never carries a verdict.
    a_tx_no_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.tx_valid |-> !r_out.verdict_valid)
        else $error("tx word carries a verdict");

    // A verdict is always the final word of its item.
    a_verdict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.verdict_valid |-> r_out.last)
        else $error("verdict word not marked last");

    // Remaining data count stays within the data limit.
    a_data_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_data_left <= MAX_DATA)
        else $error("data count beyond limit");

endmodule

// ----- verif/secure_element_packet_framer_tb.sv -----
// Self-checking testbench for the secure-element packet framer and response checker.
module secure_element_packet_framer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sepf_pkg::*;

    // Mode code that the block must ignore.
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_word  in_word = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    // Words waiting to be sent, and result words still owed by the block.
    t_in_word  stim_q[$];
    t_out_word want_q[$];
    t_out_word burst[$];

    int send_idle_pct = 13;
    int recv_stall_pct = 80;
    int queued_items = 0;
    int mismatches = 0;
    int cycles = 0;

    // Predictor state.
    t_phase      link_phase = PH_IDLE;
    logic [15:0] crc_acc = '0;
    int          data_rem = 0;
    int          rd_pos = 0;
    int          rd_total = 0;
    int          reply_cnt = 0;
    logic [7:0]  status_seen = '0;
    logic [7:0]  crc_lo_seen = '0;
    logic        crc_ok = 1'b0;

    secure_element_packet_framer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    always #6 i_clk = ~i_clk;

    // CRC-16, polynomial 0x8005, byte bits fed in least significant first.
    function automatic logic [15:0] crc16_lsb_in(input logic [15:0] acc,
                                                 input logic [7:0] octet);
        logic fb;
        for (int k = 0; k < 8; k++) begin
            fb = octet[k] ^ acc[15];
            acc = {acc[14:0], 1'b0} ^ ({16{fb}} & CRC_POLY);
        end
        return acc;
    endfunction

    function automatic t_out_word tx_word(input logic [7:0] b);
        t_out_word r;
        r = '0;
        r.tx_valid = 1'b1;
        r.tx_byte = b;
        return r;
    endfunction

    // A command byte that also feeds the running CRC.
    task automatic emit_covered(input logic [7:0] b);
        burst.push_back(tx_word(b));
        crc_acc = crc16_lsb_in(crc_acc, b);
    endtask

    task automatic emit_trailer();
        burst.push_back(tx_word(crc_acc[7:0]));
        burst.push_back(tx_word(crc_acc[15:8]));
        link_phase = PH_IDLE;
    endtask

    // Works out the result words one accepted word causes.
    task automatic frame_and_judge(input t_in_word w);
        int len;
        logic [6:0] rl;
        logic [1:0] outcome;
        t_out_word v;
        burst.delete();
        case (w.mode)
            MODE_HDR: begin
                len = (w.data_len > MAX_DATA) ? int'(MAX_DATA) : int'(w.data_len);
                crc_acc = '0;
                burst.push_back(tx_word(WORD_CMD));
                emit_covered(8'(OVERHEAD + len));
                emit_covered(w.opcode);
                emit_covered(w.param_one);
                emit_covered(w.param_two[7:0]);
                emit_covered(w.param_two[15:8]);
                if (len == 0) begin
                    emit_trailer();
                end else begin
                    data_rem = len;
                    link_phase = PH_DATA;
                end
            end
            MODE_DATA: begin
                if (link_phase == PH_DATA && data_rem != 0) begin
                    emit_covered(w.data_byte);
                    data_rem--;
                    if (data_rem == 0) begin
                        emit_trailer();
                    end
                end
            end
            MODE_RESP: begin
                if (w.first) begin
                    rl = w.read_len;
                    if (rl < SHORT_REPLY) rl = SHORT_REPLY;
                    if (rl > MAX_READ) rl = MAX_READ;
                    rd_total = rl;
                    rd_pos = 0;
                    reply_cnt = w.data_byte;
                    status_seen = '0;
                    crc_lo_seen = '0;
                    crc_ok = 1'b0;
                    crc_acc = crc16_lsb_in(16'h0000, w.data_byte);
                    link_phase = PH_READ;
                end else if (link_phase == PH_READ) begin
                    rd_pos++;
                    if (rd_pos == 1) status_seen = w.data_byte;
                    if (reply_cnt >= SHORT_REPLY) begin
                        if (rd_pos + 2 < reply_cnt) begin
                            crc_acc = crc16_lsb_in(crc_acc, w.data_byte);
                        end else if (rd_pos + 2 == reply_cnt) begin
                            crc_lo_seen = w.data_byte;
                        end else if (rd_pos + 1 == reply_cnt) begin
                            crc_ok = (crc_lo_seen == crc_acc[7:0]) &&
                                     (w.data_byte == crc_acc[15:8]);
                        end
                    end
                end
                // The verdict comes with the last byte of the read.
                if (link_phase == PH_READ && rd_pos + 1 >= rd_total) begin
                    if (reply_cnt < SHORT_REPLY || reply_cnt > rd_total) begin
                        outcome = VERDICT_CRC;
                    end else if (!crc_ok) begin
                        outcome = VERDICT_CRC;
                    end else if (reply_cnt == SHORT_REPLY && status_seen != 8'h00) begin
                        outcome = VERDICT_DEVICE;
                    end else if (reply_cnt != rd_total) begin
                        outcome = VERDICT_INVALID;
                    end else begin
                        outcome = VERDICT_OK;
                    end
                    v = '0;
                    v.verdict_valid = 1'b1;
                    v.verdict = outcome;
                    if (reply_cnt == SHORT_REPLY && crc_ok) v.dev_status = status_seen;
                    burst.push_back(v);
                    link_phase = PH_IDLE;
                end
            end
            default: begin
            end
        endcase
        if (burst.size() > 0) begin
            burst[burst.size() - 1].last = 1'b1;
        end
        foreach (burst[i]) want_q.push_back(burst[i]);
    endtask

    // Driver: presents queued words, predicts each one on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                frame_and_judge(in_word);
            end
            if (!in_valid || !in_stall) begin
                if (stim_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_word <= stim_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(input t_out_word exp_w, input t_out_word got_w,
                                   input bit none_due);
        mismatches++;
        if (mismatches <= 10) begin
            if (none_due) begin
                $display("mismatch at cycle %0d: result word with none due", cycles);
            end else begin
                $display("mismatch at cycle %0d:", cycles);
                $display("    expected tx %0b/%02h verdict %0b/%0d status %02h last %0b",
                         exp_w.tx_valid, exp_w.tx_byte, exp_w.verdict_valid,
                         exp_w.verdict, exp_w.dev_status, exp_w.last);
            end
            $display("    got tx %0b/%02h verdict %0b/%0d status %02h last %0b",
                     got_w.tx_valid, got_w.tx_byte, got_w.verdict_valid,
                     got_w.verdict, got_w.dev_status, got_w.last);
        end
    endtask

    // Monitor: checks each accepted result word against the oldest one owed.
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (want_q.size() == 0) begin
                    report_mismatch('0, out_word, 1'b1);
                end else begin
                    exp_w = want_q.pop_front();
                    if (out_word.tx_valid !== exp_w.tx_valid ||
                        out_word.tx_byte !== exp_w.tx_byte ||
                        out_word.verdict_valid !== exp_w.verdict_valid ||
                        out_word.verdict !== exp_w.verdict ||
                        out_word.dev_status !== exp_w.dev_status ||
                        out_word.last !== exp_w.last) begin
                        report_mismatch(exp_w, out_word, 1'b0);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Word builders; fields a word does not use carry random bits.
    function automatic t_in_word noise_word();
        t_in_word w;
        logic [63:0] rnd;
        rnd = {$urandom, $urandom};
        w = rnd[$bits(t_in_word)-1:0];
        return w;
    endfunction

    task automatic queue_word(input t_in_word w);
        stim_q.push_back(w);
        queued_items++;
    endtask

    task automatic queue_header(input logic [7:0] op, input logic [7:0] p1,
                                input logic [15:0] p2, input logic [6:0] len);
        t_in_word w;
        w = noise_word();
        w.mode = MODE_HDR;
        w.opcode = op;
        w.param_one = p1;
        w.param_two = p2;
        w.data_len = len;
        queue_word(w);
    endtask

    task automatic queue_data(input logic [7:0] b);
        t_in_word w;
        w = noise_word();
        w.mode = MODE_DATA;
        w.data_byte = b;
        queue_word(w);
    endtask

    task automatic queue_resp(input logic [7:0] b, input logic first,
                              input logic [6:0] rl);
        t_in_word w;
        w = noise_word();
        w.mode = MODE_RESP;
        w.data_byte = b;
        w.first = first;
        if (first) w.read_len = rl;
        queue_word(w);
    endtask

    // A response of the read length, with a valid CRC (if the count fits the read)
    // unless spoiled; only the first keep bytes are sent.
    task automatic queue_reply(input logic [6:0] rl_raw, input logic [7:0] count,
                               input logic [7:0] status, input bit spoil,
                               input int keep);
        logic [7:0] reply [0:127];
        logic [15:0] acc;
        int total;
        total = (rl_raw < SHORT_REPLY) ? int'(SHORT_REPLY) :
                (rl_raw > MAX_READ) ? int'(MAX_READ) : int'(rl_raw);
        for (int i = 0; i < total; i++) reply[i] = 8'($urandom);
        reply[0] = count;
        reply[1] = status;
        if (count >= SHORT_REPLY && count <= total) begin
            acc = '0;
            for (int i = 0; i + 2 < count; i++) acc = crc16_lsb_in(acc, reply[i]);
            reply[count - 2] = acc[7:0];
            reply[count - 1] = acc[15:8];
            if (spoil) begin
                reply[count - 1 - $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
            end
        end
        for (int i = 0; i < keep && i < total; i++) begin
            queue_resp(reply[i], i == 0, rl_raw);
        end
    endtask

    // Mostly well-formed commands and reads with random content, plus noise.
    task automatic queue_random_traffic(input int n);
        int stop_at;
        int pick;
        int len;
        int eff;
        int total;
        logic [6:0] rl;
        logic [7:0] count;
        stop_at = queued_items + n;
        while (queued_items < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                pick = $urandom_range(19);
                len = (pick < 14) ? $urandom_range(6) :
                      (pick < 18) ? $urandom_range(64, 7) : $urandom_range(127, 65);
                queue_header(8'($urandom), 8'($urandom), 16'($urandom), 7'(len));
                eff = (len > MAX_DATA) ? int'(MAX_DATA) : len;
                // Now and then the data is cut short by whatever comes next.
                if ($urandom_range(9) == 0) eff = $urandom_range(eff);
                repeat (eff) queue_data(8'($urandom));
            end else if (pick < 80) begin
                pick = $urandom_range(19);
                rl = (pick < 14) ? 7'($urandom_range(10, 4)) :
                     (pick < 18) ? 7'($urandom_range(67, 11)) : 7'($urandom_range(127));
                total = (rl < SHORT_REPLY) ? int'(SHORT_REPLY) :
                        (rl > MAX_READ) ? int'(MAX_READ) : int'(rl);
                pick = $urandom_range(9);
                count = (pick < 5) ? 8'(total) :
                        (pick < 7) ? 8'(SHORT_REPLY) :
                        (pick < 8) ? 8'($urandom_range(total, 4)) : 8'($urandom);
                queue_reply(rl, count, ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom),
                            $urandom_range(7) == 0,
                            ($urandom_range(9) == 0) ? $urandom_range(total, 1) : total);
            end else begin
                queue_word(noise_word());
            end
        end
    endtask

    // Holds the sender back until every owed result word has come; sampled
    // on the falling edge so the clocked blocks have settled.
    task automatic wait_drained();
        while (stim_q.size() != 0 || in_valid || want_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        t_in_word w;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty data with extreme header fields, then a two byte command.
        queue_header(8'hFF, 8'h00, 16'hFFFF, 7'd0);
        queue_header(8'h00, 8'hFF, 16'h0000, 7'd2);
        queue_data(8'h00);
        queue_data(8'hFF);
        // Stray data byte, unused mode, stray response byte.
        queue_data(8'h5A);
        w = noise_word();
        w.mode = MODE_UNUSED;
        queue_word(w);
        queue_resp(8'h11, 1'b0, 7'd0);
        // Oversized data length, interrupted by a new header.
        queue_header(8'h41, 8'h02, 16'h1234, 7'd127);
        queue_data(8'hC3);
        queue_data(8'h3C);
        queue_header(8'h12, 8'h80, 16'h8001, 7'd1);
        queue_data(8'h7E);
        // Short reply with device status, read length below range.
        queue_reply(7'd0, 8'd4, 8'hA5, 1'b0, 4);
        queue_reply(7'd4, 8'd4, 8'h00, 1'b0, 4);
        // A read abandoned by a new first byte, then a count above the read length.
        queue_reply(7'd5, 8'd0, 8'h00, 1'b0, 2);
        queue_reply(7'd5, 8'd255, 8'h00, 1'b0, 5);

        queue_random_traffic(157);
        wait_drained();

        send_idle_pct = 80;
        recv_stall_pct = 13;
        queue_random_traffic(157);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_random_traffic(156);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
